@@ hw/rtl/lsf_pkg.sv @@
// ----------------------------------------------------------------------------
// lsf_pkg: shared types and constants of the line fit
// Field widths of the item channels and the result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned RESULT_W = 48;
    localparam int unsigned PCOUNT_W = 11;
    localparam int unsigned FRAC_SHIFT = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [RESULT_W-1:0] result_t;
    typedef logic [PCOUNT_W-1:0]        pcount_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_VAR = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_SAT      = 2'd3
    } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/lsf_if.sv @@
// ----------------------------------------------------------------------------
// lsf_in_if / lsf_out_if: item channels of the line fit
// Valid/ready channels carrying sample pairs in and fit results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsf_in_if;
    import lsf_pkg::*;
    logic    valid;
    logic    ready;
    sample_t x_value;
    sample_t y_value;
    logic    last;

    modport source (output valid, x_value, y_value, last, input ready);
    modport sink   (input valid, x_value, y_value, last, output ready);
endinterface

interface lsf_out_if;
    import lsf_pkg::*;
    logic    valid;
    logic    ready;
    result_t slope;
    result_t intercept;
    pcount_t point_count;
    status_t status;

    modport source (output valid, slope, intercept, point_count, status, input ready);
    modport sink   (input valid, slope, intercept, point_count, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lsf_queue.sv @@
// ----------------------------------------------------------------------------
// lsf_queue: two-entry queue between accumulator and solver
// Holds finished sets of sums so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lsf_front.sv @@
// ----------------------------------------------------------------------------
// lsf_front: sample accumulator
// Takes one pair per cycle while the queue is not full, keeps count and sums,
// and hands the sums of a finished set to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_front
    import lsf_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned CNT_W      = 11,
    parameter int unsigned SX_W       = 27,
    parameter int unsigned SXY_W      = 42,
    parameter int unsigned SNAP_W     = 150
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lsf_in_if.sink                 in_ch,
    output logic                   push,
    output logic [SNAP_W-1:0]      snap,
    input  wire logic              full
);

    logic [CNT_W-1:0]        cnt_reg, cnt_next, cnt_upd;
    logic signed [SX_W-1:0]  sx_reg, sx_next, sx_upd;
    logic signed [SX_W-1:0]  sy_reg, sy_next, sy_upd;
    logic signed [SXY_W-1:0] sxy_reg, sxy_next, sxy_upd;
    logic signed [SXY_W-1:0] sxx_reg, sxx_next, sxx_upd;
    logic                    ovf_reg, ovf_next, ovf_upd;
    logic                    accept, room;
    sample_t                 xv, yv;
    logic signed [2*SAMPLE_W-1:0] pxy, pxx;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;
    assign xv          = in_ch.x_value;
    assign yv          = in_ch.y_value;
    assign pxy         = xv * yv;
    assign pxx         = xv * xv;
    assign room        = (cnt_reg < CNT_W'(MAX_POINTS));

    always_comb
    begin
        cnt_upd = cnt_reg;
        sx_upd  = sx_reg;
        sy_upd  = sy_reg;
        sxy_upd = sxy_reg;
        sxx_upd = sxx_reg;
        ovf_upd = ovf_reg | !room;
        if (room)
        begin
            cnt_upd = cnt_reg + CNT_W'(1);
            sx_upd  = sx_reg + SX_W'(xv);
            sy_upd  = sy_reg + SX_W'(yv);
            sxy_upd = sxy_reg + SXY_W'(pxy);
            sxx_upd = sxx_reg + SXY_W'(pxx);
        end

        push     = accept && in_ch.last;
        snap     = {ovf_upd, sxx_upd, sxy_upd, sy_upd, sx_upd, cnt_upd};
        cnt_next = cnt_reg;
        sx_next  = sx_reg;
        sy_next  = sy_reg;
        sxy_next = sxy_reg;
        sxx_next = sxx_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (in_ch.last)
            begin
                // The set is handed on; start the next one from nothing.
                cnt_next = '0;
                sx_next  = '0;
                sy_next  = '0;
                sxy_next = '0;
                sxx_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_upd;
                sx_next  = sx_upd;
                sy_next  = sy_upd;
                sxy_next = sxy_upd;
                sxx_next = sxx_upd;
                ovf_next = ovf_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxy_reg <= '0;
            sxx_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sxy_reg <= sxy_next;
            sxx_reg <= sxx_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lsf_div.sv @@
// ----------------------------------------------------------------------------
// lsf_div: serial saturating divider
// Restoring division of a signed numerator scaled by 256 by a positive
// denominator, one quotient bit a cycle, clamped to 48 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_div
    import lsf_pkg::*;
#(
    parameter int unsigned NUM_W = 85,
    parameter int unsigned DEN_W = 84
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic        [DEN_W-1:0] den,
    output logic                         done,
    output result_t                      quot,
    output logic                         sat
);

    localparam int unsigned SH_W = NUM_W + FRAC_SHIFT;
    localparam int unsigned SC_W = $clog2(SH_W + 1);

    logic [SH_W-1:0]  sh_reg, sh_next;
    logic [SH_W-1:0]  q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [SC_W-1:0]  step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             neg_reg, neg_next;
    logic             done_reg, done_next;
    logic             sat_reg, sat_next;
    result_t          quot_reg, quot_next;
    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [SH_W-1:0]  lim, q_c;

    assign done = done_reg;
    assign quot = quot_reg;
    assign sat  = sat_reg;

    always_comb
    begin
        mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem_sh = {rem_reg, sh_reg[SH_W-1]};
        fits   = (rem_sh >= {1'b0, den});
        lim    = neg_reg ? (SH_W'(1) << (RESULT_W - 1))
                         : ((SH_W'(1) << (RESULT_W - 1)) - SH_W'(1));
        q_c    = (q_reg > lim) ? lim : q_reg;

        sh_next   = sh_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        quot_next = quot_reg;

        if (start)
        begin
            neg_next  = num[NUM_W-1];
            sh_next   = {mag, FRAC_SHIFT'(0)};
            q_next    = '0;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg == SC_W'(SH_W))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                sat_next  = (q_reg > lim);
                quot_next = neg_reg ? -result_t'(q_c[RESULT_W-1:0])
                                    : result_t'(q_c[RESULT_W-1:0]);
            end
            else
            begin
                sh_next   = sh_reg << 1;
                q_next    = {q_reg[SH_W-2:0], fits};
                rem_next  = fits ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
                step_next = step_reg + SC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        sat_reg  <= sat_next;
        quot_reg <= quot_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lsf_back.sv @@
// ----------------------------------------------------------------------------
// lsf_back: least-squares solver
// Forms the six cross products with a shift-add multiplier, then, unless the
// denominator is zero, divides for slope and intercept; result held for out_ch.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_back
    import lsf_pkg::*;
#(
    parameter int unsigned CNT_W  = 11,
    parameter int unsigned SX_W   = 27,
    parameter int unsigned SXY_W  = 42,
    parameter int unsigned SNAP_W = 150
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SNAP_W-1:0] snap,
    input  wire logic              empty,
    output logic                   pop,
    lsf_out_if.source              out_ch
);

    localparam int unsigned PW   = 2 * SXY_W;
    localparam int unsigned BC_W = $clog2(SXY_W + 1);

    // Product order: n*Sxx, Sx*Sx, n*Sxy, Sx*Sy, Sy*Sxx, Sx*Sxy
    localparam logic [2:0] K_N_SXX  = 3'd0;
    localparam logic [2:0] K_SX_SX  = 3'd1;
    localparam logic [2:0] K_N_SXY  = 3'd2;
    localparam logic [2:0] K_SX_SY  = 3'd3;
    localparam logic [2:0] K_SY_SXX = 3'd4;
    localparam logic [2:0] K_SX_SXY = 3'd5;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MLOAD = 6'b000010,
        S_MRUN  = 6'b000100,
        S_DIV_B = 6'b001000,
        S_DIV_A = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [2:0]              k_reg, k_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SX_W-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic signed [SXY_W-1:0] sxy_reg, sxy_next, sxx_reg, sxx_next;
    logic                    ovf_reg, ovf_next;
    logic [PW-1:0]           ma_reg, ma_next, acc_reg, acc_next;
    logic [SXY_W-1:0]        mb_reg, mb_next;
    logic [BC_W-1:0]         bit_reg, bit_next;
    logic                    negp_reg, negp_next;
    logic signed [PW-1:0]    tmp_reg, tmp_next;
    logic signed [PW:0]      den_reg, den_next, nb_reg, nb_next, na_reg, na_next;
    result_t                 slope_reg, slope_next, icpt_reg, icpt_next;
    status_t                 status_reg, status_next;
    logic                    sat_reg, sat_next;

    logic signed [SXY_W-1:0] opa, opb, n_ext;
    logic signed [PW-1:0]    prod;
    logic signed [PW:0]      diff;
    logic                    div_start, div_done, div_sat;
    logic signed [PW:0]      div_num;
    result_t                 div_quot;

    lsf_div #(
        .NUM_W (PW + 1),
        .DEN_W (PW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg[PW-1:0]),
        .done  (div_done),
        .quot  (div_quot),
        .sat   (div_sat)
    );

    assign out_ch.valid       = (state_reg == S_OUT);
    assign out_ch.slope       = slope_reg;
    assign out_ch.intercept   = icpt_reg;
    assign out_ch.point_count = PCOUNT_W'(cnt_reg);
    assign out_ch.status      = status_reg;

    always_comb
    begin
        n_ext = SXY_W'(cnt_reg);
        unique case (k_reg)
            K_N_SXX:  begin opa = n_ext;         opb = sxx_reg;       end
            K_SX_SX:  begin opa = SXY_W'(sx_reg); opb = SXY_W'(sx_reg); end
            K_N_SXY:  begin opa = n_ext;         opb = sxy_reg;       end
            K_SX_SY:  begin opa = SXY_W'(sx_reg); opb = SXY_W'(sy_reg); end
            K_SY_SXX: begin opa = SXY_W'(sy_reg); opb = sxx_reg;       end
            K_SX_SXY: begin opa = SXY_W'(sx_reg); opb = sxy_reg;       end
            default:  begin opa = '0;            opb = '0;            end
        endcase
        prod = negp_reg ? -signed'(acc_reg) : signed'(acc_reg);
        diff = (PW + 1)'(tmp_reg) - (PW + 1)'(prod);
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sxy_next    = sxy_reg;
        sxx_next    = sxx_reg;
        ovf_next    = ovf_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        acc_next    = acc_reg;
        bit_next    = bit_reg;
        negp_next   = negp_reg;
        tmp_next    = tmp_reg;
        den_next    = den_reg;
        nb_next     = nb_reg;
        na_next     = na_reg;
        slope_next  = slope_reg;
        icpt_next   = icpt_reg;
        status_next = status_reg;
        sat_next    = sat_reg;
        pop         = 1'b0;
        div_start   = 1'b0;
        div_num     = (state_reg == S_MRUN) ? nb_reg : na_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    {ovf_next, sxx_next, sxy_next, sy_next, sx_next, cnt_next} = snap;
                    k_next     = K_N_SXX;
                    state_next = S_MLOAD;
                end
            end
            S_MLOAD:
            begin
                ma_next    = PW'(opa[SXY_W-1] ? SXY_W'(-opa) : SXY_W'(opa));
                mb_next    = opb[SXY_W-1] ? SXY_W'(-opb) : SXY_W'(opb);
                negp_next  = opa[SXY_W-1] ^ opb[SXY_W-1];
                acc_next   = '0;
                bit_next   = '0;
                state_next = S_MRUN;
            end
            S_MRUN:
            begin
                if (bit_reg == BC_W'(SXY_W))
                begin
                    if (!k_reg[0])
                    begin
                        tmp_next = prod;
                    end
                    else if (k_reg == K_SX_SX)
                    begin
                        den_next = diff;
                    end
                    else if (k_reg == K_SX_SY)
                    begin
                        nb_next = diff;
                    end
                    else
                    begin
                        na_next = diff;
                    end

                    if (k_reg == K_SX_SXY)
                    begin
                        if (den_reg == '0)
                        begin
                            slope_next  = '0;
                            icpt_next   = '0;
                            status_next = ST_ZERO_VAR;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV_B;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = S_MLOAD;
                    end
                end
                else
                begin
                    if (mb_reg[0])
                    begin
                        acc_next = acc_reg + ma_reg;
                    end
                    ma_next  = ma_reg << 1;
                    mb_next  = mb_reg >> 1;
                    bit_next = bit_reg + BC_W'(1);
                end
            end
            S_DIV_B:
            begin
                if (div_done)
                begin
                    slope_next = div_quot;
                    sat_next   = div_sat;
                    div_start  = 1'b1;
                    state_next = S_DIV_A;
                end
            end
            S_DIV_A:
            begin
                if (div_done)
                begin
                    icpt_next = div_quot;
                    priority if (sat_reg || div_sat)
                    begin
                        status_next = ST_SAT;
                    end
                    else if (ovf_reg)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        sxy_reg    <= sxy_next;
        sxx_reg    <= sxx_next;
        ovf_reg    <= ovf_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        acc_reg    <= acc_next;
        negp_reg   <= negp_next;
        tmp_reg    <= tmp_next;
        den_reg    <= den_next;
        nb_reg     <= nb_next;
        na_reg     <= na_next;
        slope_reg  <= slope_next;
        icpt_reg   <= icpt_next;
        status_reg <= status_next;
        sat_reg    <= sat_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/least_squares_line_fit.sv @@
// ----------------------------------------------------------------------------
// least_squares_line_fit: straight-line fit over runs of sample pairs
// Accumulates count and sums of x, y, x*y and x*x and, on the last pair of
// a set, delivers slope and intercept in Q40.8 with a status code.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                   Handshake
//  -------  ---  ----------------------------------------  -------------
//  in_ch    in   x_value, y_value, last                    valid / ready
//  out_ch   out  slope, intercept, point_count, status     valid / ready
//
// The accumulator takes one pair every cycle; its ready drops only while
// the two-entry queue of finished sets is full.
// The solver forms the cross products with a shift-add multiplier, one bit
// a cycle, and then runs the serial divider for slope and intercept; the
// cross products take the larger part of the solving time of a set.
// Reset clears the running sums, the queue and the solver state at once.
// A result waits in the output register while new pairs keep arriving.
// ----------------------------------------------------------------------------
`default_nettype none

module least_squares_line_fit
    import lsf_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 1024
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lsf_in_if.sink     in_ch,
    lsf_out_if.source  out_ch
);

    // Widths of the running count and sums follow from the set capacity.
    localparam int unsigned CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int unsigned SUM_X_W  = SAMPLE_W + CNT_W;
    localparam int unsigned SUM_XY_W = 2 * SAMPLE_W - 1 + CNT_W;
    localparam int unsigned SNAP_W   = CNT_W + 2 * SUM_X_W + 2 * SUM_XY_W + 1;

    logic              push, pop, full, empty;
    logic [SNAP_W-1:0] snap_in, snap_out;

    // Front: accumulates the pairs of the current set.
    lsf_front #(
        .MAX_POINTS (MAX_POINTS),
        .CNT_W      (CNT_W),
        .SX_W       (SUM_X_W),
        .SXY_W      (SUM_XY_W),
        .SNAP_W     (SNAP_W)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .push  (push),
        .snap  (snap_in),
        .full  (full)
    );

    // Queue of finished sets, so that accumulation runs on while solving.
    lsf_queue #(
        .WIDTH (SNAP_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (snap_in),
        .pop   (pop),
        .rdata (snap_out),
        .full  (full),
        .empty (empty)
    );

    // Back: solves the normal equations for one set at a time.
    lsf_back #(
        .CNT_W  (CNT_W),
        .SX_W   (SUM_X_W),
        .SXY_W  (SUM_XY_W),
        .SNAP_W (SNAP_W)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .snap   (snap_out),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire
